/* design/pdv_pkg.sv */
// Package for the periodic displacement variance block: field widths,
// step counts and the command and status bundles between controller and datapath.
// Depends on nothing; every other design file imports it.
package pdv_pkg;

   localparam int COORD_W    = 24;              // coordinate and box edge fields
   localparam int DISP_W     = COORD_W + 1;     // raw displacement
   localparam int FOLD_W     = COORD_W + 2;     // folding dividend, 2|d| + box
   localparam int ACC_W      = 28;              // frame sum
   localparam int SUM_W      = 38;              // sum of frame sums
   localparam int SQ_W       = 64;              // sum of squared frame sums
   localparam int SQR_W      = 2 * ACC_W;       // one squared frame sum
   localparam int HALF_W     = SUM_W / 2;       // partial product split
   localparam int PROD_W     = 32;              // split of the square sum for n * sum
   localparam int NUM_W      = 76;              // variance numerator
   localparam int FRAC_W     = 16;              // Q.16 scaling of the denominator
   localparam int SPREAD_W   = 31;
   localparam int SEEN_W     = 11;

   localparam int FOLD_STEPS = FOLD_W;          // one remainder bit per cycle
   localparam int DIV_STEPS  = NUM_W;           // one quotient bit per cycle
   localparam int CNT_W      = $clog2(NUM_W);

   localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((3 * SPREAD_W + SEEN_W + 7) / 8) * 8;

   localparam int NEIGHBOR_COUNT_DEFAULT = 12;
   localparam int MAX_FRAMES_DEFAULT     = 1024;

   typedef struct packed {
      logic load;       // take a new item into the lanes
      logic fold_step;  // one step of the minimum-image remainder
      logic accum;      // add the folded displacement to the frame sum
      logic drop;       // frame rejected: clear the frame sum, flag overflow
      logic square;     // square the closed frame sum
      logic update;     // add the closed frame into the series
      logic mul0;       // variance numerator, partial products
      logic mul1;
      logic mul2;
      logic mul3;
      logic num_load;   // form the numerator and start the division
      logic div_step;   // one quotient bit
      logic finish;     // load the result register and clear the frame and series state
   } cmd_type;

   typedef struct packed {
      logic close;      // the current item closes a frame
      logic send;       // the current item ends the series
      logic full;       // the frame counter has reached its limit
   } status_type;

endpackage

/* design/pdv_lane.sv */
// One axis of the datapath: minimum-image fold by restoring remainder, frame and
// series accumulation, variance numerator and a bit-serial quotient.
// Depends on pdv_pkg.
module pdv_lane #(
   parameter int TALLY_W = pdv_pkg::SEEN_W,
   parameter int DEN_W   = 2 * 14 + pdv_pkg::FRAC_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pdv_pkg::cmd_type                       cmd,
   input  logic signed [pdv_pkg::COORD_W-1:0]     atom,
   input  logic signed [pdv_pkg::COORD_W-1:0]     nbr,
   input  logic        [pdv_pkg::COORD_W-1:0]     box,
   input  logic        [TALLY_W-1:0]              tally,
   input  logic        [DEN_W-1:0]                den,
   output logic        [pdv_pkg::SPREAD_W-1:0]    spread
);
   import pdv_pkg::*;

   localparam int PA_W = TALLY_W + PROD_W;

   // state that the series keeps
   logic signed [ACC_W-1:0]  frame_acc_ff, frame_acc_in;
   logic signed [SUM_W-1:0]  series_sum_ff, series_sum_in;
   logic        [SQ_W-1:0]   series_square_ff, series_square_in;

   // working registers
   logic signed [DISP_W-1:0] disp_ff, disp_in;
   logic        [COORD_W-1:0] box_ff, box_in;
   logic        [FOLD_W-1:0] fnum_ff, fnum_in;
   logic        [DISP_W-1:0] frem_ff, frem_in;
   logic        [SQR_W-1:0]  sqr_ff, sqr_in;
   logic        [PA_W-1:0]   pa_ff, pa_in;
   logic        [2*HALF_W-1:0] pb_ff, pb_in;
   logic        [NUM_W-1:0]  numa_ff, numa_in;
   logic        [NUM_W-1:0]  numb_ff, numb_in;
   logic        [NUM_W-1:0]  num_ff, num_in;
   logic        [DEN_W-1:0]  qrem_ff, qrem_in;
   logic        [SPREAD_W-1:0] q_ff, q_in;
   logic                     sat_ff, sat_in;

   logic signed [DISP_W-1:0] disp_new;
   logic        [DISP_W-1:0] disp_mag;
   logic        [FOLD_W-1:0] fshift, fdiv;
   logic                     fge;
   logic signed [FOLD_W-1:0] half_diff, fold_t, folded;
   logic        [ACC_W-1:0]  acc_mag;
   logic        [SUM_W-1:0]  sum_mag;
   logic        [HALF_W-1:0] sum_lo, sum_hi;
   logic        [DEN_W:0]    qshift, qden;
   logic                     qge;

   assign disp_new = {nbr[COORD_W-1], nbr} - {atom[COORD_W-1], atom};
   assign disp_mag = disp_new[DISP_W-1] ? DISP_W'(-disp_new) : DISP_W'(disp_new);

   // Remainder of (2|d| + box) by 2 box, one bit per step.
   assign fshift = {frem_ff, fnum_ff[FOLD_W-1]};
   assign fdiv   = {1'b0, box_ff, 1'b0};
   assign fge    = (fshift >= fdiv);

   // (rem - box) / 2 is the folded magnitude with its sign; it is always even.
   assign half_diff = $signed({1'b0, frem_ff}) - $signed({2'b00, box_ff});
   assign fold_t    = half_diff >>> 1;
   assign folded    = (box_ff == '0)        ? {disp_ff[DISP_W-1], disp_ff} :
                      disp_ff[DISP_W-1]     ? -fold_t : fold_t;

   assign acc_mag = frame_acc_ff[ACC_W-1] ? ACC_W'(-frame_acc_ff) : ACC_W'(frame_acc_ff);
   assign sum_mag = series_sum_ff[SUM_W-1] ? SUM_W'(-series_sum_ff) : SUM_W'(series_sum_ff);
   assign sum_lo  = sum_mag[HALF_W-1:0];
   assign sum_hi  = sum_mag[SUM_W-1:HALF_W];

   assign qshift = {qrem_ff, num_ff[NUM_W-1]};
   assign qden   = {1'b0, den};
   assign qge    = (qshift >= qden);

   assign spread = sat_ff ? '1 : q_ff;

   always_comb begin
      frame_acc_in     = frame_acc_ff;
      series_sum_in    = series_sum_ff;
      series_square_in = series_square_ff;
      disp_in  = disp_ff;
      box_in   = box_ff;
      fnum_in  = fnum_ff;
      frem_in  = frem_ff;
      sqr_in   = sqr_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      numa_in  = numa_ff;
      numb_in  = numb_ff;
      num_in   = num_ff;
      qrem_in  = qrem_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;

      if (cmd.load) begin
         disp_in = disp_new;
         box_in  = box;
         fnum_in = FOLD_W'({disp_mag, 1'b0}) + FOLD_W'(box);
         frem_in = '0;
      end
      if (cmd.fold_step) begin
         frem_in = fge ? DISP_W'(fshift - fdiv) : DISP_W'(fshift);
         fnum_in = {fnum_ff[FOLD_W-2:0], 1'b0};
      end
      if (cmd.accum) begin
         frame_acc_in = frame_acc_ff + {{(ACC_W-FOLD_W){folded[FOLD_W-1]}}, folded};
      end
      if (cmd.drop) begin
         frame_acc_in = '0;
      end
      if (cmd.square) begin
         sqr_in = acc_mag * acc_mag;
      end
      if (cmd.update) begin
         series_sum_in    = series_sum_ff + {{(SUM_W-ACC_W){frame_acc_ff[ACC_W-1]}}, frame_acc_ff};
         series_square_in = series_square_ff + SQ_W'(sqr_ff);
         frame_acc_in     = '0;
      end
      // n * sum(s^2) in two halves, sum(s)^2 in three partial products
      if (cmd.mul0) begin
         pa_in = tally * series_square_ff[PROD_W-1:0];
         pb_in = sum_lo * sum_lo;
      end
      if (cmd.mul1) begin
         numa_in = NUM_W'(pa_ff);
         numb_in = NUM_W'(pb_ff);
         pa_in   = tally * series_square_ff[SQ_W-1:PROD_W];
         pb_in   = sum_lo * sum_hi;
      end
      if (cmd.mul2) begin
         numa_in = numa_ff + (NUM_W'(pa_ff) << PROD_W);
         numb_in = numb_ff + (NUM_W'(pb_ff) << (HALF_W + 1));
         pb_in   = sum_hi * sum_hi;
      end
      if (cmd.mul3) begin
         numb_in = numb_ff + (NUM_W'(pb_ff) << (2 * HALF_W));
      end
      if (cmd.num_load) begin
         num_in  = (numa_ff < numb_ff) ? '0 : numa_ff - numb_ff;
         qrem_in = '0;
         q_in    = '0;
         sat_in  = 1'b0;
      end
      if (cmd.div_step) begin
         qrem_in = qge ? DEN_W'(qshift - qden) : DEN_W'(qshift);
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         q_in    = {q_ff[SPREAD_W-2:0], qge};
         sat_in  = sat_ff | q_ff[SPREAD_W-1];
      end
      if (cmd.finish) begin
         frame_acc_in     = '0;
         series_sum_in    = '0;
         series_square_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_acc_ff     <= '0;
         series_sum_ff    <= '0;
         series_square_ff <= '0;
      end else begin
         frame_acc_ff     <= frame_acc_in;
         series_sum_ff    <= series_sum_in;
         series_square_ff <= series_square_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff <= disp_in;
      box_ff  <= box_in;
      fnum_ff <= fnum_in;
      frem_ff <= frem_in;
      sqr_ff  <= sqr_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      numa_ff <= numa_in;
      numb_ff <= numb_in;
      num_ff  <= num_in;
      qrem_ff <= qrem_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
   end

endmodule

/* design/pdv_datapath.sv */
// Datapath: three axis lanes, the frame counter, overflow flag, the shared
// variance denominator and the result register.
// Depends on pdv_pkg and pdv_lane.
module pdv_datapath #(
   parameter int NEIGHBOR_COUNT = pdv_pkg::NEIGHBOR_COUNT_DEFAULT,
   parameter int MAX_FRAMES     = pdv_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pdv_pkg::cmd_type                    cmd,
   output pdv_pkg::status_type                 status,
   input  logic signed [pdv_pkg::COORD_W-1:0]  atom_x,
   input  logic signed [pdv_pkg::COORD_W-1:0]  atom_y,
   input  logic signed [pdv_pkg::COORD_W-1:0]  atom_z,
   input  logic signed [pdv_pkg::COORD_W-1:0]  nbr_x,
   input  logic signed [pdv_pkg::COORD_W-1:0]  nbr_y,
   input  logic signed [pdv_pkg::COORD_W-1:0]  nbr_z,
   input  logic        [pdv_pkg::COORD_W-1:0]  box_x,
   input  logic        [pdv_pkg::COORD_W-1:0]  box_y,
   input  logic        [pdv_pkg::COORD_W-1:0]  box_z,
   input  logic                                frame_end,
   input  logic                                series_end,
   output logic        [pdv_pkg::SPREAD_W-1:0] spread_x,
   output logic        [pdv_pkg::SPREAD_W-1:0] spread_y,
   output logic        [pdv_pkg::SPREAD_W-1:0] spread_z,
   output logic        [pdv_pkg::SEEN_W-1:0]   frames_seen,
   output logic                                frames_overflow
);
   import pdv_pkg::*;

   localparam int TALLY_W = $clog2(MAX_FRAMES + 1);
   localparam int NC_W    = $clog2(MAX_FRAMES * NEIGHBOR_COUNT + 1);
   localparam int DEN_W   = 2 * NC_W + FRAC_W;

   logic               close_ff, close_in;
   logic               send_ff, send_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               ovf_ff, ovf_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [2*NC_W-1:0]  nc_square;

   logic [SPREAD_W-1:0] lane_x, lane_y, lane_z;
   logic [SPREAD_W-1:0] spread_x_ff, spread_x_in;
   logic [SPREAD_W-1:0] spread_y_ff, spread_y_in;
   logic [SPREAD_W-1:0] spread_z_ff, spread_z_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic                ovf_out_ff, ovf_out_in;
   logic                no_frames;

   pdv_lane #(.TALLY_W(TALLY_W), .DEN_W(DEN_W)) u_lane_x (
      .clock (clock), .reset (reset), .cmd (cmd),
      .atom (atom_x), .nbr (nbr_x), .box (box_x),
      .tally (tally_ff), .den (den_ff), .spread (lane_x)
   );

   pdv_lane #(.TALLY_W(TALLY_W), .DEN_W(DEN_W)) u_lane_y (
      .clock (clock), .reset (reset), .cmd (cmd),
      .atom (atom_y), .nbr (nbr_y), .box (box_y),
      .tally (tally_ff), .den (den_ff), .spread (lane_y)
   );

   pdv_lane #(.TALLY_W(TALLY_W), .DEN_W(DEN_W)) u_lane_z (
      .clock (clock), .reset (reset), .cmd (cmd),
      .atom (atom_z), .nbr (nbr_z), .box (box_z),
      .tally (tally_ff), .den (den_ff), .spread (lane_z)
   );

   assign status.close = close_ff;
   assign status.send  = send_ff;
   assign status.full  = (tally_ff >= TALLY_W'(MAX_FRAMES));

   assign nc_square = nc_ff * nc_ff;
   assign no_frames = (tally_ff == '0);

   always_comb begin
      close_in    = close_ff;
      send_in     = send_ff;
      tally_in    = tally_ff;
      ovf_in      = ovf_ff;
      nc_in       = nc_ff;
      den_in      = den_ff;
      spread_x_in = spread_x_ff;
      spread_y_in = spread_y_ff;
      spread_z_in = spread_z_ff;
      seen_in     = seen_ff;
      ovf_out_in  = ovf_out_ff;

      if (cmd.load) begin
         close_in = frame_end | series_end;
         send_in  = series_end;
      end
      if (cmd.update) begin
         tally_in = tally_ff + TALLY_W'(1);
      end
      if (cmd.drop) begin
         ovf_in = 1'b1;
      end
      // (n * count)^2 scaled by 2^16, ready before the division starts
      if (cmd.mul0) begin
         nc_in = NC_W'(tally_ff) * NC_W'(NEIGHBOR_COUNT);
      end
      if (cmd.mul1) begin
         den_in = {nc_square, {FRAC_W{1'b0}}};
      end
      if (cmd.finish) begin
         spread_x_in = no_frames ? '0 : lane_x;
         spread_y_in = no_frames ? '0 : lane_y;
         spread_z_in = no_frames ? '0 : lane_z;
         seen_in     = SEEN_W'(tally_ff);
         ovf_out_in  = ovf_ff;
         tally_in    = '0;
         ovf_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         close_ff <= 1'b0;
         send_ff  <= 1'b0;
         tally_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         close_ff <= close_in;
         send_ff  <= send_in;
         tally_ff <= tally_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      nc_ff       <= nc_in;
      den_ff      <= den_in;
      spread_x_ff <= spread_x_in;
      spread_y_ff <= spread_y_in;
      spread_z_ff <= spread_z_in;
      seen_ff     <= seen_in;
      ovf_out_ff  <= ovf_out_in;
   end

   assign spread_x        = spread_x_ff;
   assign spread_y        = spread_y_ff;
   assign spread_z        = spread_z_ff;
   assign frames_seen     = seen_ff;
   assign frames_overflow = ovf_out_ff;

endmodule

/* design/pdv_ctrl.sv */
// Controller: sequences one item through fold, accumulate and frame close, and
// at series end through the numerator products and the quotient loop.
// Depends on pdv_pkg.
module pdv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  pdv_pkg::status_type status,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output pdv_pkg::cmd_type    cmd
);
   import pdv_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_FOLD   = 13'b0000000000010,
      S_ACCUM  = 13'b0000000000100,
      S_DROP   = 13'b0000000001000,
      S_SQUARE = 13'b0000000010000,
      S_UPDATE = 13'b0000000100000,
      S_MUL0   = 13'b0000001000000,
      S_MUL1   = 13'b0000010000000,
      S_MUL2   = 13'b0000100000000,
      S_MUL3   = 13'b0001000000000,
      S_NUM    = 13'b0010000000000,
      S_DIV    = 13'b0100000000000,
      S_FINISH = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold_step = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FOLD_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (!status.close) begin
               state_in = S_IDLE;
            end else if (status.full) begin
               state_in = S_DROP;
            end else begin
               state_in = S_SQUARE;
            end
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = status.send ? S_MUL0 : S_IDLE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.send ? S_MUL0 : S_IDLE;
         end
         S_MUL0: begin
            cmd.mul0 = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.num_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/periodic_displacement_variance_top.sv */
// Top level of the periodic displacement variance block: port packing and the
// controller and datapath instances.
// Depends on pdv_pkg, pdv_ctrl and pdv_datapath.
//
// Usage. Each request transaction carries one atom position, one neighbour
// position and the three box edges. The block folds each displacement to the
// minimum image and sums it into the running frame. req_tuser marks the last
// neighbour of a frame; req_tlast marks the last item of the series and also
// closes the frame. A response transaction is produced only for the item that
// carries req_tlast: the variance of the frame means on each axis, the number
// of frames counted and a flag for frames dropped beyond the frame limit.
// An item is taken only in the idle state, so the next item waits until the last
// one has been through the bit-serial remainder of the minimum-image fold and,
// where it closes a frame, the drop or the entry into the statistics.
// At series end the response follows the numerator products and the 76-step
// quotient loop, which runs on all three axes at once.
// Reset clears the frame sums, the series sums, the frame counter, the overflow
// flag and the response valid. A stalled response is held in its register;
// new items are still taken meanwhile, and a later response waits until the
// earlier one has been accepted.
module periodic_displacement_variance_top #(
   parameter int NEIGHBOR_COUNT = pdv_pkg::NEIGHBOR_COUNT_DEFAULT,
   parameter int MAX_FRAMES     = pdv_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // atom_x, atom_y, atom_z, nbr_x, nbr_y, nbr_z, box_x, box_y, box_z (24 bits each)
   input  logic [pdv_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                               req_tuser,   // frame_end
   input  logic                               req_tlast,   // series_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // spread_x, spread_y, spread_z (31 bits each), frames_seen (11 bits)
   output logic [pdv_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser    // frames_overflow
);
   import pdv_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [SPREAD_W-1:0] spread_x, spread_y, spread_z;
   logic [SEEN_W-1:0]   frames_seen;
   logic                frames_overflow;

   pdv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The request fields are sampled straight from the bus on the accepting edge.
   pdv_datapath #(
      .NEIGHBOR_COUNT (NEIGHBOR_COUNT),
      .MAX_FRAMES     (MAX_FRAMES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .atom_x          (req_tdata[0*COORD_W +: COORD_W]),
      .atom_y          (req_tdata[1*COORD_W +: COORD_W]),
      .atom_z          (req_tdata[2*COORD_W +: COORD_W]),
      .nbr_x           (req_tdata[3*COORD_W +: COORD_W]),
      .nbr_y           (req_tdata[4*COORD_W +: COORD_W]),
      .nbr_z           (req_tdata[5*COORD_W +: COORD_W]),
      .box_x           (req_tdata[6*COORD_W +: COORD_W]),
      .box_y           (req_tdata[7*COORD_W +: COORD_W]),
      .box_z           (req_tdata[8*COORD_W +: COORD_W]),
      .frame_end       (req_tuser),
      .series_end      (req_tlast),
      .spread_x        (spread_x),
      .spread_y        (spread_y),
      .spread_z        (spread_z),
      .frames_seen     (frames_seen),
      .frames_overflow (frames_overflow)
   );

   // Response fields packed from the lowest bit up, zero filled to whole bytes.
   assign rsp_tdata = OUT_DATA_W'({frames_seen, spread_z, spread_y, spread_x});
   assign rsp_tuser = frames_overflow;

endmodule

/* design/pdv_checker.sv */
// Port-level checker for the periodic displacement variance block, and the bind
// that attaches it to the top level.
// Depends on pdv_pkg and periodic_displacement_variance_top.
module pdv_checker #(
   parameter int MAX_FRAMES = pdv_pkg::MAX_FRAMES_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [pdv_pkg::IN_DATA_W-1:0]  req_tdata,
   input logic                           req_tuser,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pdv_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import pdv_pkg::*;

   localparam int SEEN_LSB = 3 * SPREAD_W;

   logic [SEEN_W-1:0] seen;
   logic              req_take;

   assign seen     = rsp_tdata[SEEN_LSB +: SEEN_W];
   assign req_take = req_tvalid && req_tready && (req_tdata == req_tdata)
                     && (req_tuser == req_tuser);

   // No response may be pending straight after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // An item that does not end the series cannot raise a response next cycle.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("response raised by an item without series end");

   // The overflow flag only ever comes with a full frame count.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> seen == SEEN_W'(MAX_FRAMES))
      else $error("overflow reported below the frame limit");

endmodule

bind periodic_displacement_variance_top pdv_checker #(.MAX_FRAMES(MAX_FRAMES)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* bench/tb_top.sv */
// Self-checking bench for periodic_displacement_variance_top: directed and random
// neighbour transactions, a running prediction of each variance report, field checks.
// Depends on pdv_pkg and the periodic_displacement_variance_top RTL.
module tb_top;

   // The block is built with its default sizes; the bench mirrors them.
   localparam int NEIGHBOURS    = pdv_pkg::NEIGHBOR_COUNT_DEFAULT;
   localparam int FRAME_LIMIT   = pdv_pkg::MAX_FRAMES_DEFAULT;
   localparam int ACC_BITS      = pdv_pkg::ACC_W;
   localparam int SUM_BITS      = pdv_pkg::SUM_W;
   localparam int SQ_BITS       = pdv_pkg::SQ_W;
   localparam int SEEN_BITS     = pdv_pkg::SEEN_W;
   localparam int SPREAD_BITS   = pdv_pkg::SPREAD_W;
   localparam int FRACTION_BITS = pdv_pkg::FRAC_W;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int DIRECTED_ROWS = 10;
   localparam int RANDOM_ITEMS  = 820;
   localparam int RANDOM_SERIES = 30;
   // Run on after the last report with ample margin.
   localparam int TAIL_CYCLES   = 200;
   localparam int LIMIT_CYCLES  = 400000;

   localparam logic [23:0] PMAX = 24'h7FFFFF;   // largest positive coordinate
   localparam logic [23:0] NMIN = 24'h800000;   // most negative coordinate
   localparam logic [23:0] BMAX = 24'hFFFFFF;   // largest box edge
   localparam logic [SPREAD_BITS-1:0] SPREAD_CEILING = '1;

   // One request transaction: atom, neighbour and box per axis, index 0 is x.
   // The first field sits in the lowest bits, exactly as req_tdata packs them.
   typedef struct packed {
      logic [2:0][23:0] box;
      logic [2:0][23:0] nbr;
      logic [2:0][23:0] atom;
   } coords_type;

   // One response transaction: rsp_tuser on top of the rsp_tdata fields.
   typedef struct packed {
      logic                          ovf;
      logic [SEEN_BITS-1:0]          seen;
      logic [2:0][SPREAD_BITS-1:0]   spread;
   } variance_report_type;

   // A row of the directed table. Where lone is set the response is typed in:
   // a series of a single frame always has zero spread.
   typedef struct packed {
      coords_type pos;
      logic       frame_end;
      logic       series_end;
      logic [7:0] count;
      logic       lone;
   } stimulus_row_type;

   localparam variance_report_type LONE_FRAME = {1'b0, 11'd1, 93'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [pdv_pkg::IN_DATA_W-1:0] req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          req_tlast  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [pdv_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                          rsp_tuser;

   // Expected variance reports, oldest first, and the bookkeeping of the run.
   variance_report_type pending_reports[$];
   int  mismatches        = 0;
   int  items_sent        = 0;
   int  series_sent       = 0;
   int  responses_checked = 0;
   int  burst_left        = 0;

   // Mirror of the block's statistics.
   logic signed [ACC_BITS-1:0] frame_total  [3];
   logic signed [SUM_BITS-1:0] series_total [3];
   logic        [SQ_BITS-1:0]  series_power [3];
   int                         frames_counted;
   logic                       overflow_flag;

   stimulus_row_type directed_rows [DIRECTED_ROWS];

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   periodic_displacement_variance_top #(
      .NEIGHBOR_COUNT (NEIGHBOURS),
      .MAX_FRAMES     (FRAME_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic void clear_model();
      int k;
      for (k = 0; k < 3; k++) begin
         frame_total[k]  = '0;
         series_total[k] = '0;
         series_power[k] = '0;
      end
      frames_counted = 0;
      overflow_flag  = 1'b0;
   endfunction

   // Minimum image: take away the nearest whole number of box lengths, with a
   // displacement of exactly half a box rounded away from zero. A zero edge
   // leaves the axis unfolded.
   function automatic longint fold_axis(input longint d, input longint box);
      longint mag;
      longint wraps;
      if (box == 0)
         return d;
      mag   = (d < 0) ? -d : d;
      wraps = (2 * mag + box) / (2 * box);
      return (d < 0) ? d + wraps * box : d - wraps * box;
   endfunction

   // Population variance of the frame means on one axis, in units of 2^16:
   // (n * sum(s^2) - sum(s)^2) / (n^2 * NEIGHBOURS^2 * 2^16), truncated.
   function automatic logic [SPREAD_BITS-1:0] axis_variance(input int ax);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] quo;
      logic [63:0]  mag;
      logic [63:0]  den;
      longint       st;
      if (frames_counted == 0)
         return '0;
      lhs = 128'(frames_counted) * 128'(series_power[ax]);
      st  = longint'(series_total[ax]);
      mag = (st < 0) ? 64'(-st) : 64'(st);
      rhs = 128'(mag) * 128'(mag);
      // A numerator below zero only comes about once the sums have wrapped.
      if (lhs < rhs)
         return '0;
      den = 64'(frames_counted * NEIGHBOURS);
      den = (den * den) << FRACTION_BITS;
      quo = (lhs - rhs) / 128'(den);
      return (quo > 128'(SPREAD_CEILING)) ? SPREAD_CEILING : quo[SPREAD_BITS-1:0];
   endfunction

   // Takes one accepted item into the mirror; returns 1 with the report when
   // the item ends the series.
   function automatic bit advance_model(input coords_type pos, input logic fe,
                                        input logic se, output variance_report_type report);
      int                  k;
      longint              d;
      longint              st;
      longint unsigned     mag;
      report = '0;
      for (k = 0; k < 3; k++) begin
         d = longint'(signed'(pos.nbr[k])) - longint'(signed'(pos.atom[k]));
         frame_total[k] = ACC_BITS'(longint'(frame_total[k]) + fold_axis(d, longint'(pos.box[k])));
      end
      if (fe || se) begin
         if (frames_counted < FRAME_LIMIT) begin
            for (k = 0; k < 3; k++) begin
               st  = longint'(frame_total[k]);
               mag = (st < 0) ? -st : st;
               series_total[k] = SUM_BITS'(longint'(series_total[k]) + st);
               series_power[k] = series_power[k] + mag * mag;
            end
            frames_counted++;
         end else begin
            overflow_flag = 1'b1;
         end
         for (k = 0; k < 3; k++)
            frame_total[k] = '0;
      end
      if (!se)
         return 1'b0;
      for (k = 0; k < 3; k++)
         report.spread[k] = axis_variance(k);
      report.seen = SEEN_BITS'(frames_counted);
      report.ovf  = overflow_flag;
      clear_model();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic stimulus_row_type row(input logic [23:0] ax, ay, az, nx, ny, nz,
                                            bx, by, bz, input logic fe, se,
                                            input int count, input bit lone);
      stimulus_row_type s;
      s.pos.atom   = {az, ay, ax};
      s.pos.nbr    = {nz, ny, nx};
      s.pos.box    = {bz, by, bx};
      s.frame_end  = fe;
      s.series_end = se;
      s.count      = 8'(count);
      s.lone       = lone;
      return s;
   endfunction

   // Mostly neighbours within 0x20000 of the atom, some anywhere;
   // box edges from tiny to full scale, with the odd zero edge.
   function automatic coords_type random_coords();
      coords_type pos;
      int         k;
      for (k = 0; k < 3; k++) begin
         pos.atom[k] = 24'($urandom());
         if ($urandom_range(0, 3) == 0)
            pos.nbr[k] = 24'($urandom());
         else
            pos.nbr[k] = pos.atom[k] + 24'($urandom_range(0, 'h3FFFF)) - 24'h20000;
         case ($urandom_range(0, 15))
            0:             pos.box[k] = '0;
            1:             pos.box[k] = BMAX;
            2:             pos.box[k] = 24'($urandom_range(1, 8));
            3, 4, 5, 6, 7: pos.box[k] = 24'($urandom_range(1, 'h3FFFF));
            default:       pos.box[k] = 24'($urandom());
         endcase
      end
      return pos;
   endfunction

   // Presents one request transaction and waits for it to be taken. Called at
   // a rising edge; returns at the edge on which the transaction was accepted,
   // so that the next item can follow without a gap.
   task automatic push_item(input coords_type pos, input logic fe, input logic se,
                            input bit lone, input variance_report_type lone_want);
      variance_report_type report;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         // Mostly short gaps, sometimes long enough to land anywhere in the
         // block's per-item fold.
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pos;
      req_tuser  <= fe;
      req_tlast  <= se;
      do
         @(posedge clock);
      while (!req_tready);
      if (advance_model(pos, fe, se, report)) begin
         pending_reports = {pending_reports, (lone ? lone_want : report)};
         series_sent++;
      end
      items_sent++;
      if (burst_left > 0)
         burst_left--;
   endtask

   // Holds the sender back until every expected report has come in.
   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_reports.size() != 0);
   endtask

   // Well-formed series of whole frames with random content, and a share of
   // ragged series whose frames have any length.
   task automatic send_random_series();
      int frames;
      int len;
      int f;
      int i;
      if ($urandom_range(0, 9) < 7) begin
         frames = $urandom_range(1, 4);
         for (f = 0; f < frames; f++)
            for (i = 0; i < NEIGHBOURS; i++)
               push_item(random_coords(),
                         (i == NEIGHBOURS - 1) && (f < frames - 1 || $urandom_range(0, 1) == 1),
                         (i == NEIGHBOURS - 1) && (f == frames - 1), 1'b0, '0);
      end else begin
         len = $urandom_range(1, 20);
         for (i = 0; i < len; i++)
            push_item(random_coords(), $urandom_range(0, 3) == 0, i == len - 1, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // The receiver stalls on a 16-bit pattern that is drawn afresh each time it
   // runs out: often always ready, sometimes a full stall, otherwise random.
   logic [15:0] stall_pattern = '1;
   logic [3:0]  stall_phase   = '0;

   always @(posedge clock) begin
      if (stall_phase == 4'd0) begin
         case ($urandom_range(0, 7))
            0, 1, 2: stall_pattern = '1;
            3:       stall_pattern = '0;
            default: stall_pattern = 16'($urandom());
         endcase
      end
      rsp_tready  <= stall_pattern[stall_phase];
      stall_phase  = stall_phase + 4'd1;
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Every response transaction is checked field by field against the oldest
   // outstanding report.
   always @(posedge clock) begin : response_check
      variance_report_type want;
      variance_report_type got;
      int                  k;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_checked++;
         got = {rsp_tuser, rsp_tdata};
         if (pending_reports.size() == 0) begin
            report_mismatch("response with nothing outstanding, count", 0, 1);
         end else begin
            want = pending_reports.pop_front();
            for (k = 0; k < 3; k++)
               if (got.spread[k] !== want.spread[k])
                  report_mismatch($sformatf("spread on axis %0d", k), want.spread[k], got.spread[k]);
            if (got.seen !== want.seen)
               report_mismatch("frames_seen", want.seen, got.seen);
            if (got.ovf !== want.ovf)
               report_mismatch("frames_overflow", want.ovf, got.ovf);
         end
      end
   end

   // ------------------------------------------------------------------
   // Run sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int r;
      int n;
      int first_item;
      int first_series;
      clear_model();
      // Columns: atom x y z, neighbour x y z, box x y z, frame end, series end,
      // repeat count, typed single-frame result.
      directed_rows = '{
         // Series end straight after reset: one frame, no spread.
         row(0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 1, 1, 1),
         // Displacements of exactly half a box, both signs, and just under half.
         row(0, 0, 0, 1, 24'hFFFFFF, 1, 2, 2, 3, 0, 0, 1, 0),
         // Widest positive displacement against the largest box; closes a frame.
         row(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, BMAX, BMAX, BMAX, 1, 0, 1, 0),
         // Widest negative displacement against the smallest box.
         row(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN, 1, 1, 1, 0, 0, 1, 0),
         // Zero box edges leave the displacement unfolded; ends the series.
         row(NMIN, 0, 24'h123456, PMAX, 24'h654321, 0, 0, 0, 0, 0, 1, 1, 0),
         // Two long frames at opposite extremes: the largest spread reachable.
         row(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, 0, 0, 0, 0, 0, 7, 0),
         row(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, 0, 0, 0, 1, 0, 1, 0),
         row(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN, 0, 0, 0, 0, 0, 7, 0),
         row(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN, 0, 0, 0, 0, 1, 1, 0),
         // Frame end and series end on the same item: again a single frame.
         row(0, 0, 0, 0, 0, 0, BMAX, BMAX, BMAX, 1, 1, 1, 1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++)
         for (n = 0; n < directed_rows[r].count; n++)
            push_item(directed_rows[r].pos, directed_rows[r].frame_end,
                      directed_rows[r].series_end, directed_rows[r].lone, LONE_FRAME);

      // The sender stands still until the directed reports are all in.
      wait_for_reports();

      first_item   = items_sent;
      first_series = series_sent;
      while (items_sent - first_item < RANDOM_ITEMS || series_sent - first_series < RANDOM_SERIES)
         send_random_series();

      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d responses against %0d neighbour items in %0d series.",
               responses_checked, items_sent, series_sent);
      $display("Covered folding extremes, half-box rounding, zero boxes and ragged frames.");
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // A run that stalls ends here rather than hanging.
   initial begin : watchdog
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("Timeout with %0d responses outstanding", pending_reports.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
design/pdv_pkg.sv
design/pdv_lane.sv
design/pdv_datapath.sv
design/pdv_ctrl.sv
design/periodic_displacement_variance_top.sv
design/pdv_checker.sv
bench/tb_top.sv
